// ===== hw/rtl/multi_pattern_occurrence_counter_defines.svh =====
// Assertion macros shared by the occurrence counter RTL.
// Depends on nothing; each user supplies clk and rst_n in scope.
`ifndef MULTI_PATTERN_OCCURRENCE_COUNTER_DEFINES_SVH
`define MULTI_PATTERN_OCCURRENCE_COUNTER_DEFINES_SVH

// property checked on every clock outside reset
`define MPOC_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen
`define MPOC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/mpoc_pkg.sv =====
// Shared types and constants of the multi-pattern occurrence counter.
// No dependencies.
package mpoc_pkg;

    localparam int DEF_MAX_PATTERNS = 128;
    localparam int DEF_MAX_LEN      = 255;
    localparam int DEF_COUNT_WIDTH  = 40;

    localparam int KIND_W    = 3;
    localparam int SYM_W     = 8;
    localparam int MATCH_W   = 40;
    localparam int PTOTAL_W  = 8;
    localparam int QDEPTH    = 2;

    localparam logic [KIND_W-1:0] KIND_PBYTE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] op;
        logic [SYM_W-1:0]  sym;
    } cmd_t;

endpackage

// ===== hw/rtl/mpoc_front.sv =====
// Front end: accepts items, drops unused kinds, queues commands.
// Depends on mpoc_pkg.
module mpoc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [mpoc_pkg::KIND_W-1:0] kind,
    input  logic [mpoc_pkg::SYM_W-1:0]  symbol,
    output mpoc_pkg::cmd_t         cmd,
    output logic                   cmd_valid,
    input  logic                   cmd_ready
);
    import mpoc_pkg::*;
    `include "multi_pattern_occurrence_counter_defines.svh"

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             q_reg [QDEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign busy      = (cnt_reg == CNT_W'(QDEPTH));
    assign push      = start && !busy && (kind <= KIND_CLEAR);
    assign cmd_valid = (cnt_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= '{op: kind, sym: symbol};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    `MPOC_NEVER(a_cnt_range, cnt_reg > CNT_W'(QDEPTH), "queue count above depth")
    `MPOC_CHECK(a_push_holds, push |=> cnt_reg != '0, "pushed item lost")
    `MPOC_CHECK(a_wrap, (cnt_reg == '0) |-> (wr_reg == rd_reg), "empty queue pointers differ")

endmodule

// ===== hw/rtl/mpoc_back.sv =====
// Back end: executes commands; pattern rows in memory, scanned one per cycle.
// Depends on mpoc_pkg.
module mpoc_back #(
    parameter int MAX_PATTERNS = mpoc_pkg::DEF_MAX_PATTERNS,
    parameter int MAX_LEN      = mpoc_pkg::DEF_MAX_LEN,
    parameter int COUNT_WIDTH  = mpoc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mpoc_pkg::cmd_t                cmd,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    output logic                          result_valid,
    output logic [mpoc_pkg::MATCH_W-1:0]  match_total,
    output logic [mpoc_pkg::PTOTAL_W-1:0] pattern_total,
    output logic                          overflow
);
    import mpoc_pkg::*;
    `include "multi_pattern_occurrence_counter_defines.svh"

    localparam int WW = MAX_LEN * SYM_W;
    localparam int AW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int PW = $clog2(MAX_PATTERNS + 1);
    localparam int LW = $clog2(MAX_LEN + 2);
    localparam int EW = LW + WW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [EW-1:0]          mem [MAX_PATTERNS];
    logic [1:0]             state_reg;
    logic [WW-1:0]          win_reg;
    logic [LW-1:0]          fill_reg;
    logic [WW-1:0]          row_reg;
    logic [LW-1:0]          load_reg;
    logic [PW-1:0]          stored_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic                   ovf_reg;
    logic [AW-1:0]          p_reg;
    logic                   rv_reg;
    logic [EW-1:0]          rdata_reg;
    logic                   mv_reg;
    logic                   match_reg;
    logic                   res_reg;
    logic [MATCH_W-1:0]     mt_reg;
    logic [PTOTAL_W-1:0]    pt_reg;
    logic                   take;
    logic                   mem_we;
    logic                   hit;
    logic [LW-1:0]          rlen;
    logic [WW-1:0]          rrow;

    assign cmd_ready     = (state_reg == ST_IDLE);
    assign take          = cmd_valid && cmd_ready;
    assign mem_we        = take && (cmd.op == KIND_CLOSE) && (load_reg != '0)
                           && (load_reg <= LW'(MAX_LEN))
                           && (stored_reg < PW'(MAX_PATTERNS));
    assign rlen          = rdata_reg[EW-1:WW];
    assign rrow          = rdata_reg[WW-1:0];
    assign result_valid  = res_reg;
    assign match_total   = mt_reg;
    assign pattern_total = pt_reg;
    assign overflow      = ovf_reg && res_reg;

    // newest byte sits at byte 0 in both the window and the pattern row
    always_comb
    begin
        hit = (rlen != '0) && (rlen <= fill_reg);
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if ((LW'(i) < rlen) && (rrow[i*SYM_W +: SYM_W] != win_reg[i*SYM_W +: SYM_W]))
            begin
                hit = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[AW'(stored_reg)] <= {load_reg, row_reg};
        end
        rdata_reg <= mem[p_reg];
        match_reg <= hit;
        if (take && (cmd.op == KIND_PBYTE))
        begin
            row_reg <= WW'({row_reg, cmd.sym});
        end
        mt_reg <= MATCH_W'(count_reg);
        pt_reg <= PTOTAL_W'(stored_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            win_reg    <= '0;
            fill_reg   <= '0;
            load_reg   <= '0;
            stored_reg <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            p_reg      <= '0;
            rv_reg     <= 1'b0;
            mv_reg     <= 1'b0;
            res_reg    <= 1'b0;
        end
        else
        begin
            rv_reg  <= (state_reg == ST_SCAN);
            mv_reg  <= rv_reg;
            res_reg <= take && (cmd.op == KIND_END);

            if (mv_reg && match_reg)
            begin
                if (count_reg != {COUNT_WIDTH{1'b1}})
                begin
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    p_reg <= '0;
                    if (take)
                    begin
                        case (cmd.op)
                            KIND_PBYTE:
                            begin
                                if (load_reg <= LW'(MAX_LEN))
                                begin
                                    load_reg <= load_reg + 1'b1;
                                end
                            end
                            KIND_CLOSE:
                            begin
                                if (load_reg != '0)
                                begin
                                    if (mem_we)
                                    begin
                                        stored_reg <= stored_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        ovf_reg <= 1'b1;
                                    end
                                    load_reg <= '0;
                                end
                            end
                            KIND_TEXT:
                            begin
                                win_reg <= WW'({win_reg, cmd.sym});
                                if (fill_reg < LW'(MAX_LEN))
                                begin
                                    fill_reg <= fill_reg + 1'b1;
                                end
                                if (stored_reg != '0)
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            KIND_END:
                            begin
                                win_reg   <= '0;
                                fill_reg  <= '0;
                                count_reg <= '0;
                            end
                            KIND_CLEAR:
                            begin
                                stored_reg <= '0;
                                load_reg   <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    p_reg <= p_reg + 1'b1;
                    if ((PW'(p_reg) + PW'(1)) == stored_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rv_reg && !mv_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `MPOC_NEVER(a_stored_max, stored_reg > PW'(MAX_PATTERNS), "pattern count above table size")
    `MPOC_NEVER(a_fill_max, fill_reg > LW'(MAX_LEN), "window fill above window size")
    `MPOC_CHECK(a_idle_quiet, (state_reg == ST_IDLE) |-> !mv_reg, "match pending while idle")
    `MPOC_CHECK(a_end_clears, res_reg |-> (count_reg == '0), "count not cleared after report")

endmodule

// ===== hw/rtl/multi_pattern_occurrence_counter.sv =====
// Top level of the multi-pattern occurrence counter.
// Depends on mpoc_pkg, mpoc_front and mpoc_back.
//
//  channel | handshake            | payload
//  input   | start / busy         | kind, symbol
//  result  | result_valid (1 clk) | match_total, pattern_total, overflow
//
// A text byte occupies the back end while the stored pattern rows are scanned and
// the match pipeline drains, with no scan when none is stored: the pattern memory
// gives one row per cycle. Other kinds leave the back end idle; a result is on the
// ports in the cycle after its item leaves the queue registers.
// busy rises only while the two-entry queue is full.
// Reset clears control state at once; there is no clearing pass.
// The receiver cannot stall: result_valid is a one-cycle strobe.
module multi_pattern_occurrence_counter #(
    parameter int MAX_PATTERNS = mpoc_pkg::DEF_MAX_PATTERNS,
    parameter int MAX_LEN      = mpoc_pkg::DEF_MAX_LEN,
    parameter int COUNT_WIDTH  = mpoc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mpoc_pkg::KIND_W-1:0]   kind,
    input  logic [mpoc_pkg::SYM_W-1:0]    symbol,
    output logic                          result_valid,
    output logic [mpoc_pkg::MATCH_W-1:0]  match_total,
    output logic [mpoc_pkg::PTOTAL_W-1:0] pattern_total,
    output logic                          overflow
);
    import mpoc_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    mpoc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .symbol    (symbol),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    mpoc_back #(
        .MAX_PATTERNS (MAX_PATTERNS),
        .MAX_LEN      (MAX_LEN),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .result_valid  (result_valid),
        .match_total   (match_total),
        .pattern_total (pattern_total),
        .overflow      (overflow)
    );

endmodule

// ===== tb/sv/multi_pattern_occurrence_counter_checker.sv =====
// Checker for the multi-pattern occurrence counter: follows accepted items,
// predicts end-of-text results and compares them. Depends on mpoc_pkg.
`timescale 1ns / 100ps
module multi_pattern_occurrence_counter_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  kind,
    input  logic [7:0]  symbol,
    input  logic        result_valid,
    input  logic [39:0] match_total,
    input  logic [7:0]  pattern_total,
    input  logic        overflow,
    output int          failures,
    output int          pending,
    output int          reports_seen
);
    import mpoc_pkg::*;

    localparam int NPAT = DEF_MAX_PATTERNS;
    localparam int PLEN = DEF_MAX_LEN;
    localparam logic [39:0] COUNT_SAT = '1;

    typedef struct packed {
        logic [39:0] total;
        logic [7:0]  npat;
        logic        ovf;
    } report_t;

    logic [7:0]  window [PLEN];
    int          fill;
    logic [7:0]  pat_bytes [NPAT][PLEN];
    int          pat_len [NPAT];
    int          npat_stored;
    int          loading;
    logic [39:0] occ_count;
    logic        sticky_ovf;
    report_t     expected_reports [$];

    function automatic bit pattern_hits(int p);
        int n;
        n = pat_len[p];
        if (n == 0 || n > fill)
            return 0;
        for (int i = 0; i < n; i++)
            if (window[PLEN - n + i] != pat_bytes[p][i])
                return 0;
        return 1;
    endfunction

    task automatic absorb_item(logic [2:0] k, logic [7:0] s);
        report_t r;
        case (k)
            KIND_PBYTE:
            begin
                if (npat_stored < NPAT && loading < PLEN)
                    pat_bytes[npat_stored][loading] = s;
                if (loading <= PLEN)
                    loading++;
            end
            KIND_CLOSE:
            begin
                if (loading != 0)
                begin
                    if (loading > PLEN || npat_stored >= NPAT)
                        sticky_ovf = 1;
                    else
                    begin
                        pat_len[npat_stored] = loading;
                        npat_stored++;
                    end
                    loading = 0;
                end
            end
            KIND_TEXT:
            begin
                for (int i = 0; i < PLEN - 1; i++)
                    window[i] = window[i + 1];
                window[PLEN - 1] = s;
                if (fill < PLEN)
                    fill++;
                for (int p = 0; p < npat_stored; p++)
                    if (pattern_hits(p))
                    begin
                        if (occ_count != COUNT_SAT)
                            occ_count++;
                        else
                            sticky_ovf = 1;
                    end
            end
            KIND_END:
            begin
                r.total = occ_count;
                r.npat = npat_stored[7:0];
                r.ovf = sticky_ovf;
                expected_reports.push_back(r);
                for (int i = 0; i < PLEN; i++)
                    window[i] = '0;
                fill = 0;
                occ_count = '0;
            end
            KIND_CLEAR:
            begin
                npat_stored = 0;
                loading = 0;
            end
            default: ;
        endcase
    endtask

    initial
    begin
        failures = 0;
        reports_seen = 0;
        for (int i = 0; i < PLEN; i++)
            window[i] = '0;
        fill = 0;
        npat_stored = 0;
        loading = 0;
        occ_count = '0;
        sticky_ovf = 0;
    end

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n)
        begin
            if (result_valid)
            begin
                reports_seen++;
                if (expected_reports.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected report: total=%0d npat=%0d ovf=%0b",
                                 match_total, pattern_total, overflow);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (want.total !== match_total || want.npat !== pattern_total
                        || want.ovf !== overflow)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("report mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     want.total, want.npat, want.ovf,
                                     match_total, pattern_total, overflow);
                    end
                end
            end
            if (start && !busy)
                absorb_item(kind, symbol);
        end
        pending = expected_reports.size();
    end
endmodule

// ===== tb/sv/multi_pattern_occurrence_counter_test.sv =====
// Stimulus and verdict for the multi-pattern occurrence counter.
// Depends on mpoc_pkg, the block and multi_pattern_occurrence_counter_checker.
`timescale 1ns / 100ps
module multi_pattern_occurrence_counter_test;
    import mpoc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [7:0]  symbol;
    logic        result_valid;
    logic [39:0] match_total;
    logic [7:0]  pattern_total;
    logic        overflow;
    int          failures;
    int          pending;
    int          reports_seen;
    int          sent;
    int          idle_pct;

    multi_pattern_occurrence_counter uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .symbol(symbol), .result_valid(result_valid), .match_total(match_total),
        .pattern_total(pattern_total), .overflow(overflow)
    );

    multi_pattern_occurrence_counter_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .symbol(symbol), .result_valid(result_valid), .match_total(match_total),
        .pattern_total(pattern_total), .overflow(overflow),
        .failures(failures), .pending(pending), .reports_seen(reports_seen)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #200ms;
        $display("[multi_pattern_occurrence_counter] ERROR");
        $finish;
    end

    // one item, held at the falling edge until accepted
    task automatic issue(logic [2:0] k, logic [7:0] s);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(negedge clk);
        end
        start <= 1;
        kind <= k;
        symbol <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic load_pattern(int n, logic [7:0] base, int alpha);
        for (int i = 0; i < n; i++)
            issue(KIND_PBYTE, 8'(base + $urandom_range(alpha - 1)));
        issue(KIND_CLOSE, 8'($urandom));
    endtask

    task automatic feed_text(int n, logic [7:0] base, int alpha);
        for (int i = 0; i < n; i++)
            issue(KIND_TEXT, 8'(base + $urandom_range(alpha - 1)));
    endtask

    initial
    begin
        logic [7:0] b;
        int r;
        start = 0;
        kind = KIND_PBYTE;
        symbol = '0;
        rst_n = 0;
        sent = 0;
        idle_pct = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty pattern, extreme bytes, overlaps, unused kinds
        issue(KIND_CLOSE, 8'hff);
        issue(KIND_END, 8'h00);
        issue(KIND_PBYTE, 8'h00);
        issue(KIND_PBYTE, 8'h00);
        issue(KIND_CLOSE, 8'h00);
        issue(KIND_PBYTE, 8'hff);
        issue(KIND_CLOSE, 8'h00);
        issue(KIND_PBYTE, 8'hff);
        issue(KIND_TEXT, 8'h00);
        issue(KIND_TEXT, 8'h00);
        issue(KIND_TEXT, 8'h00);
        issue(KIND_TEXT, 8'hff);
        issue(KIND_CLOSE, 8'h00);
        issue(KIND_TEXT, 8'hff);
        issue(3'd5, 8'h55);
        issue(3'd6, 8'haa);
        issue(3'd7, 8'hff);
        issue(KIND_END, 8'hff);
        issue(KIND_CLEAR, 8'h00);
        issue(KIND_END, 8'h00);

        // too-long pattern sets the sticky flag
        for (int i = 0; i < 257; i++)
            issue(KIND_PBYTE, i[7:0]);
        issue(KIND_CLOSE, 8'h00);
        issue(KIND_END, 8'h00);

        // full table: many one-byte patterns, plus one dropped
        issue(KIND_CLEAR, 8'h00);
        for (int i = 0; i < 129; i++)
        begin
            issue(KIND_PBYTE, 8'h5a);
            issue(KIND_CLOSE, 8'h00);
        end
        feed_text(3, 8'h5a, 1);
        issue(KIND_END, 8'h00);
        // longest pattern against a full window
        issue(KIND_CLEAR, 8'h00);
        load_pattern(255, 8'h33, 1);
        feed_text(260, 8'h33, 1);
        issue(KIND_END, 8'h00);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 70 : (phase == 3) ? 33 : 0;
            while (sent < 1250 + phase * 220)
            begin
                issue(KIND_CLEAR, 8'h00);
                r = $urandom_range(1, 4);
                b = 8'($urandom);
                for (int p = 0; p < r; p++)
                    load_pattern($urandom_range(1, 4), b, 3);
                for (int t = 0; t < 3; t++)
                begin
                    feed_text($urandom_range(0, 15), b, 3);
                    if ($urandom_range(9) == 0)
                        issue(3'($urandom), 8'($urandom));
                    if ($urandom_range(5) == 0)
                        issue(KIND_PBYTE, b);
                    if ($urandom_range(5) == 0)
                        issue(KIND_CLOSE, 8'($urandom));
                    issue(KIND_END, 8'($urandom));
                end
            end
        end
        start <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Sent %0d items over four idle phases; %0d end-of-text reports checked.",
                 sent, reports_seen);
        if (failures == 0)
            $display("[multi_pattern_occurrence_counter] OK");
        else
            $display("[multi_pattern_occurrence_counter] ERROR");
        $finish;
    end
endmodule
